// File: design/lca_pkg.sv
// Shared types and constants for the line command assembler.
package lca_pkg;

   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_CR  = 8'h0D;

   localparam int         LIMIT_W     = 6;
   localparam logic [5:0] LIMIT_MAX   = 6'd32;
   localparam logic [5:0] LIMIT_RESET = 6'd32;

   typedef enum logic [1:0] {
      KIND_ECHO = 2'd0,
      KIND_CHAR = 2'd1,
      KIND_END  = 2'd2
   } kind_type;

   typedef struct packed {
      logic load_echo;
      logic echo_last;
      logic load_char;
      logic load_end;
      logic start_line;
      logic clear_fill;
      logic append;
   } lca_cmd_type;

   typedef struct packed {
      logic is_nul;
      logic is_term;
      logic fill_nz;
      logic store_full;
      logic more_chars;
      logic slot_free;
   } lca_status_type;

endpackage

// File: design/lca_req_if.sv
// Received-byte channel.
interface lca_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source(output valid, output rx_byte, input ready);
   modport sink(input valid, input rx_byte, output ready);
endinterface

// File: design/lca_rsp_if.sv
// Result channel: echo, command characters and end marker.
interface lca_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] char_out;
   logic       last;

   modport source(output valid, output kind, output char_out, output last, input ready);
   modport sink(input valid, input kind, input char_out, input last, output ready);
endinterface

// File: design/lca_csr_if.sv
// Register write channel for the output limit.
interface lca_csr_if;
   logic       valid;
   logic       ready;
   logic [5:0] out_limit;

   modport source(output valid, output out_limit, input ready);
   modport sink(input valid, input out_limit, output ready);
endinterface

// File: design/lca_datapath.sv
// Datapath: line store, fill and walk counters, limit register, result register.
module lca_datapath #(
   parameter int LINE_CAP = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lca_pkg::lca_cmd_type    cmd,
   output lca_pkg::lca_status_type status,
   input  logic [7:0]             rx_byte,
   input  logic                   csr_write,
   input  logic [5:0]             csr_data,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_kind,
   output logic [7:0]             rsp_char,
   output logic                   rsp_last
);
   import lca_pkg::*;

   localparam int DEPTH = LINE_CAP - 1;
   localparam int FW    = $clog2(LINE_CAP);
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = (FW > 5) ? FW : 5;

   logic [7:0]         store_mem [DEPTH];
   logic [7:0]         rd_data_ff;

   logic [FW-1:0]      fill_ff, fill_in;
   logic [FW-1:0]      idx_ff, idx_in;
   logic [FW-1:0]      cnt_ff, cnt_in;
   logic [LIMIT_W-1:0] limit_ff;

   logic               valid_ff, valid_in;
   kind_type           kind_ff, kind_in;
   logic [7:0]         char_ff, char_in;
   logic               last_ff, last_in;

   logic [4:0]         lim_m1;
   logic [CW-1:0]      fill_ext, lim_ext;

   // Effective limit minus one: zero acts as one, above 32 saturates.
   always_comb begin
      if (limit_ff == '0) begin
         lim_m1 = 5'd0;
      end else if (limit_ff > LIMIT_MAX) begin
         lim_m1 = 5'(LIMIT_MAX - 6'd1);
      end else begin
         lim_m1 = 5'(limit_ff - 6'd1);
      end
      fill_ext = CW'(fill_ff);
      lim_ext  = CW'(lim_m1);
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.start_line) begin
         cnt_in = (fill_ext > lim_ext) ? lim_ext[FW-1:0] : fill_ff;
      end

      fill_in = fill_ff;
      if (cmd.clear_fill) begin
         fill_in = '0;
      end else if (cmd.append) begin
         fill_in = fill_ff + FW'(1);
      end

      idx_in = idx_ff;
      if (cmd.start_line) begin
         idx_in = '0;
      end else if (cmd.load_char) begin
         idx_in = idx_ff + FW'(1);
      end
   end

   always_comb begin
      valid_in = valid_ff & ~rsp_ready;
      kind_in  = kind_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (cmd.load_echo) begin
         valid_in = 1'b1;
         kind_in  = KIND_ECHO;
         char_in  = rx_byte;
         last_in  = cmd.echo_last;
      end else if (cmd.load_char) begin
         valid_in = 1'b1;
         kind_in  = KIND_CHAR;
         char_in  = rd_data_ff;
         last_in  = 1'b0;
      end else if (cmd.load_end) begin
         valid_in = 1'b1;
         kind_in  = KIND_END;
         char_in  = CHAR_NUL;
         last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         idx_ff   <= '0;
         cnt_ff   <= '0;
         limit_ff <= LIMIT_RESET;
         valid_ff <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
         if (csr_write) begin
            limit_ff <= csr_data;
         end
      end
      kind_ff <= kind_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   // Read at the next walk index so the data lines up with idx_ff.
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         store_mem[fill_ff[AW-1:0]] <= rx_byte;
      end
      if (idx_in < FW'(DEPTH)) begin
         rd_data_ff <= store_mem[idx_in[AW-1:0]];
      end
   end

   always_comb begin
      status.is_nul     = (rx_byte == CHAR_NUL);
      status.is_term    = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
      status.fill_nz    = (fill_ff != '0);
      status.store_full = (fill_ff == FW'(DEPTH));
      status.more_chars = (idx_ff < cnt_ff);
      status.slot_free  = ~valid_ff | rsp_ready;
   end

   assign rsp_valid = valid_ff;
   assign rsp_kind  = kind_ff;
   assign rsp_char  = char_ff;
   assign rsp_last  = last_ff;

endmodule

// File: design/lca_controller.sv
// Controller: takes bytes and sequences the line walk.
module lca_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lca_pkg::lca_status_type status,
   output lca_pkg::lca_cmd_type    cmd
);
   import lca_pkg::*;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_WALK
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      accept    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = status.slot_free;
            accept    = req_valid & status.slot_free;
            if (accept && !status.is_nul) begin
               cmd.load_echo = 1'b1;
               if (status.is_term) begin
                  cmd.clear_fill = 1'b1;
                  if (status.fill_nz) begin
                     cmd.start_line = 1'b1;
                     state_in       = ST_WALK;
                  end else begin
                     cmd.echo_last = 1'b1;
                  end
               end else begin
                  cmd.echo_last = 1'b1;
                  cmd.append    = ~status.store_full;
               end
            end
         end
         ST_WALK: begin
            if (status.slot_free) begin
               if (status.more_chars) begin
                  cmd.load_char = 1'b1;
               end else begin
                  cmd.load_end = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/line_command_assembler.sv
// Line command assembler top level: controller, datapath and assertions.
// Each nonzero received byte is echoed; CR or LF ends a line and, if characters are
// held, the line (cut to out_limit minus one characters) and an end marker follow
// the echo. A plain byte or zero byte is taken without leaving the idle state. A
// terminator of a line with n delivered characters occupies the block while results
// drain at one per cycle, stalling while the result is not taken: the line store has
// one read port and the controller walks it one entry a cycle under the same stall,
// so the next byte is taken once the end marker is loaded. A new byte is taken while
// the result register is empty or in the cycle its waiting result transfers.
// The line store needs no clearing pass after reset; the limit register can be
// written at any time the block is idle and is always ready.
module line_command_assembler #(
   parameter int LINE_CAP = 32
) (
   input logic        clock,
   input logic        reset,
   lca_req_if.sink    req_chan,
   lca_rsp_if.source  rsp_chan,
   lca_csr_if.sink    csr_chan
);
   import lca_pkg::*;

   lca_cmd_type    cmd;
   lca_status_type status;

   assign csr_chan.ready = 1'b1;

   lca_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lca_datapath #(
      .LINE_CAP (LINE_CAP)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .rx_byte   (req_chan.rx_byte),
      .csr_write (csr_chan.valid),
      .csr_data  (csr_chan.out_limit),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_kind  (rsp_chan.kind),
      .rsp_char  (rsp_chan.char_out),
      .rsp_last  (rsp_chan.last)
   );

   a_one_load: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_echo, cmd.load_char, cmd.load_end}))
      else $error("more than one result loaded in a cycle");

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      cmd.append |-> !status.store_full)
      else $error("append into a full line store");

   a_char_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load_char |-> status.more_chars)
      else $error("command character loaded past the line count");

   a_line_echo: assert property (@(posedge clock) disable iff (reset)
      cmd.start_line |=> (rsp_chan.valid && rsp_chan.kind == KIND_ECHO && !rsp_chan.last))
      else $error("line walk did not start with a non-final echo");

endmodule
